[src/redpm_pkg.sv]
// Package for the random error-diffusion palette mapper: codes, constants and helpers.
package redpm_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;
  typedef logic signed [8:0] err_t;
  typedef logic [7:0] chan_t;

  localparam action_t ACT_APPEND = 2'd0;
  localparam action_t ACT_MAP    = 2'd1;
  localparam action_t ACT_START  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic [47:0] SEED_RESET = 48'h1234ABCD330E;
  localparam logic [47:0] LCG_ADD    = 48'h00000000000B;
  localparam logic [15:0] LCG_M0     = 16'hE66D;
  localparam logic [15:0] LCG_M1     = 16'hDEEC;
  localparam logic [15:0] LCG_M2     = 16'h0005;

  localparam logic [8:0] CHAN_MAX = 9'd255;

  function automatic chan_t clamp_chan(input chan_t px, input err_t carry);
    logic signed [9:0] sum;
    begin
      sum = $signed({2'b00, px}) + $signed({carry[8], carry});
      if (sum < 0) begin
        clamp_chan = 8'd0;
      end else if (sum > $signed({1'b0, CHAN_MAX})) begin
        clamp_chan = CHAN_MAX[7:0];
      end else begin
        clamp_chan = sum[7:0];
      end
    end
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    begin
      abs_diff = (a >= b) ? (a - b) : (b - a);
    end
  endfunction

endpackage

[src/random_error_diffusion_palette_map.sv]
// Top level of the random error-diffusion palette mapper.
// Append, start and unknown words go from idle to the output state, which registers the result.
// Map word: generator draws on one 16x16 multiplier, then a search that reads one palette
// entry per cycle, then drain, best-entry read and error write; empty palette: straight
// from adjust to output. The next word is taken once the result is out.
// A stalled result holds the input stalled. Sync reset (rst_n low): palette empty, left
// errors clear, generator and seed at the seed reset value; no clearing pass.
module random_error_diffusion_palette_map
  import redpm_pkg::*;
#(
  parameter int MAX_WIDTH    = 4096,
  parameter int PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [11:0] in_column,
  input  logic        in_row_start,
  input  logic        in_first_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_color_index,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PAW = $clog2(PALETTE_SIZE);
  localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [PAW:0] PAL_MAX = (PAW+1)'(PALETTE_SIZE);
  localparam int MOD_SH = 12 + $clog2(MAX_WIDTH);
  localparam logic [13:0] MOD_RECIP =
    14'(((64'd1 << MOD_SH) + 64'(MAX_WIDTH) - 64'd1) / 64'(MAX_WIDTH));
  localparam logic [11:0] MOD_D12 = 12'(MAX_WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAW   = 3'd1;
  localparam logic [2:0] S_ADJ    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RDBEST = 3'd5;
  localparam logic [2:0] S_ERRW   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]     state_r;
  logic           diffuse_r;
  logic [47:0]    seed_r;
  logic [47:0]    gen_r;
  logic [47:0]    acc_r;
  logic [2:0]     step_r;
  logic [1:0]     ch_r;
  logic [2:0]     pick_r;
  logic [11:0]    quo_r;
  logic [11:0]    rem_r;
  logic [PAW:0]   cnt_r;
  logic [PAW-1:0] k_r;
  logic [PAW-1:0] best_r;
  logic [17:0]    best_d_r;
  logic           rd_valid_r;
  logic [PAW-1:0] rd_idx_r;
  logic           sq_valid_r;
  logic [PAW-1:0] sq_idx_r;
  logic [15:0]    sq_r [3];
  chan_t          px_r [3];
  chan_t          adj_r [3];
  err_t           left_r [3];
  logic           row_start_r;
  logic           first_row_r;
  logic [PAW-1:0] res_idx_r;
  status_t        res_status_r;
  logic           out_valid_r;
  logic [7:0]     out_idx_r;
  status_t        out_status_r;

  logic           in_acc;
  logic           cfg_wr;
  logic           pal_full;
  logic           pal_we;
  logic [PAW-1:0] pal_raddr;
  logic [23:0]    pal_rdata;
  logic [CAW-1:0] col_idx;
  logic           col_we;
  logic [26:0]    col_wdata;
  logic [26:0]    col_rdata;
  logic [15:0]    mul_a;
  logic [15:0]    mul_b;
  logic [5:0]     mul_sh;
  logic [31:0]    prod;
  logic [47:0]    acc_nxt;
  logic [25:0]    mod_prod;
  logic [11:0]    mod_quo;
  logic           last_issue;
  logic [17:0]    dist_sum;
  logic           out_free;
  chan_t          adj_nxt [3];
  err_t           err_nxt [3];
  logic [15:0]    sq_nxt [3];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = paddr[3] ? {16'd0, seed_r} : {63'd0, diffuse_r};

  assign pal_full   = (cnt_r >= PAL_MAX);
  assign pal_we     = in_acc && (in_action == ACT_APPEND) && !pal_full;
  assign pal_raddr  = (state_r == S_SEARCH) ? k_r : best_r;
  assign col_idx    = CAW'(rem_r);
  assign col_we     = (state_r == S_ERRW) && diffuse_r;
  assign col_wdata  = {err_nxt[0], err_nxt[1], err_nxt[2]};
  assign last_issue = ((PAW+1)'({1'b0, k_r}) + (PAW+1)'(1)) == cnt_r;
  assign out_free   = !out_valid_r || !out_stall;

  redpm_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (cnt_r[PAW-1:0]),
    .wdata ({in_red, in_green, in_blue}),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  redpm_ram #(.WIDTH(27), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_idx),
    .wdata (col_wdata),
    .raddr (col_idx),
    .rdata (col_rdata)
  );

  // generator: one 16x16 partial product per cycle, six per draw
  always_comb begin
    unique case (step_r)
      3'd0: begin mul_a = gen_r[15:0];  mul_b = LCG_M0; mul_sh = 6'd0;  end
      3'd1: begin mul_a = gen_r[15:0];  mul_b = LCG_M1; mul_sh = 6'd16; end
      3'd2: begin mul_a = gen_r[31:16]; mul_b = LCG_M0; mul_sh = 6'd16; end
      3'd3: begin mul_a = gen_r[15:0];  mul_b = LCG_M2; mul_sh = 6'd32; end
      3'd4: begin mul_a = gen_r[31:16]; mul_b = LCG_M1; mul_sh = 6'd32; end
      3'd5: begin mul_a = gen_r[47:32]; mul_b = LCG_M0; mul_sh = 6'd32; end
      default: begin mul_a = 16'd0; mul_b = 16'd0; mul_sh = 6'd0; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_nxt = acc_r + (48'(prod) << mul_sh);

  // column reduction by reciprocal multiplication
  assign mod_prod = {14'd0, rem_r} * {12'd0, MOD_RECIP};
  assign mod_quo  = 12'(mod_prod >> MOD_SH);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      err_t carry;
      carry = '0;
      if (diffuse_r) begin
        if (pick_r[c]) begin
          carry = row_start_r ? err_t'(0) : left_r[c];
        end else begin
          carry = first_row_r ? err_t'(0) : $signed(col_rdata[26-9*c -: 9]);
        end
      end
      adj_nxt[c] = clamp_chan(px_r[c], carry);
      err_nxt[c] = $signed({1'b0, px_r[c]}) - $signed({1'b0, pal_rdata[23-8*c -: 8]});
      sq_nxt[c]  = 16'(abs_diff(adj_r[c], pal_rdata[23-8*c -: 8]))
                 * 16'(abs_diff(adj_r[c], pal_rdata[23-8*c -: 8]));
    end
  end

  assign dist_sum = 18'(sq_r[0]) + 18'(sq_r[1]) + 18'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      diffuse_r   <= 1'b0;
      seed_r      <= SEED_RESET;
      gen_r       <= SEED_RESET;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      sq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      ch_r        <= '0;
      for (int c = 0; c < 3; c++) begin
        left_r[c] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[3]) begin
          seed_r <= pwdata[47:0];
        end else begin
          diffuse_r <= pwdata[0];
        end
      end

      rd_valid_r <= (state_r == S_SEARCH);
      sq_valid_r <= rd_valid_r;

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (in_action == ACT_MAP) ? S_DRAW : S_OUT;
            unique case (in_action)
              ACT_APPEND: begin
                if (!pal_full) begin
                  cnt_r <= cnt_r + (PAW+1)'(1);
                end
              end
              ACT_MAP: begin
                step_r <= '0;
                ch_r   <= '0;
              end
              ACT_START: begin
                gen_r <= seed_r;
                for (int c = 0; c < 3; c++) begin
                  left_r[c] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DRAW: begin
          if (step_r == 3'd5) begin
            gen_r  <= acc_nxt;
            step_r <= '0;
            ch_r   <= ch_r + 2'd1;
            if (ch_r == 2'd2) begin
              state_r <= S_ADJ;
            end
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_ADJ: begin
          state_r <= (cnt_r == '0) ? S_OUT : S_SEARCH;
        end
        S_SEARCH: begin
          if (last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid_r && !sq_valid_r) begin
            state_r <= S_RDBEST;
          end
        end
        S_RDBEST: begin
          state_r <= S_ERRW;
        end
        S_ERRW: begin
          if (diffuse_r) begin
            for (int c = 0; c < 3; c++) begin
              left_r[c] <= err_nxt[c];
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      res_idx_r    <= (in_action == ACT_APPEND && !pal_full) ? cnt_r[PAW-1:0] : '0;
      res_status_r <= (in_action == ACT_APPEND && pal_full) ? ST_FULL : ST_OK;
      px_r[0]      <= in_red;
      px_r[1]      <= in_green;
      px_r[2]      <= in_blue;
      rem_r        <= in_column;
      row_start_r  <= in_row_start;
      first_row_r  <= in_first_row;
      acc_r        <= LCG_ADD;
    end

    if (state_r == S_DRAW) begin
      if (step_r == 3'd5) begin
        acc_r          <= LCG_ADD;
        pick_r[ch_r]   <= acc_nxt[17];
      end else begin
        acc_r <= acc_nxt;
      end
      if (ch_r == 2'd0) begin
        if (step_r == 3'd0) begin
          quo_r <= mod_quo;
        end else if (step_r == 3'd1) begin
          rem_r <= rem_r - quo_r * MOD_D12;
        end
      end
    end

    if (state_r == S_ADJ) begin
      for (int c = 0; c < 3; c++) begin
        adj_r[c] <= adj_nxt[c];
      end
      k_r      <= '0;
      best_r   <= '0;
      best_d_r <= '1;
      if (cnt_r == '0) begin
        res_status_r <= ST_EMPTY;
      end
    end

    if (state_r == S_SEARCH) begin
      k_r <= k_r + PAW'(1);
    end

    rd_idx_r <= k_r;
    sq_idx_r <= rd_idx_r;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= sq_nxt[c];
    end

    if (sq_valid_r && dist_sum < best_d_r) begin
      best_d_r <= dist_sum;
      best_r   <= sq_idx_r;
    end

    if (state_r == S_ERRW) begin
      res_idx_r <= best_r;
    end

    if (state_r == S_OUT && out_free) begin
      out_idx_r    <= 8'(res_idx_r);
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;
  assign out_status      = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PAL_MAX)
    else $error("palette count beyond palette size");

  a_pipe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (state_r == S_SEARCH || state_r == S_DRAIN))
    else $error("search read outside search");

  a_map_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_MAP) |=> (state_r == S_DRAW))
    else $error("map word did not start generator draws");

  a_col_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADJ) |-> ({20'd0, rem_r} < 32'(MAX_WIDTH)))
    else $error("column not reduced before error read");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDBEST) |-> ((PAW+1)'({1'b0, best_r}) < cnt_r))
    else $error("best index outside loaded palette");

endmodule

[src/redpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module redpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[dv/random_error_diffusion_palette_map_tb.sv]
// Self-checking testbench for the random error-diffusion palette mapper.
module random_error_diffusion_palette_map_tb
  import redpm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_DEPTH = 256;
  localparam int COL_DEPTH = 4096;
  localparam int LIMIT = 3000000;
  localparam action_t ACT_UNUSED = 2'd3;
  localparam logic [3:0] ADDR_DIFFUSE = 4'd0;
  localparam logic [3:0] ADDR_SEED = 4'd8;
  localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;

  typedef struct packed {
    action_t     action;
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    logic [11:0] column;
    logic        row_start;
    logic        first_row;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] index;
    status_t    status;
  } map_code_t;

  class palette_shadow;
    logic [23:0] pal [PAL_DEPTH];
    int unsigned count;
    err_t        col_err [COL_DEPTH][3];
    bit          col_set [COL_DEPTH];
    err_t        left_err [3];
    logic [47:0] gen;
    logic [47:0] seed;
    bit          diffuse;
    map_code_t   due [$];
    int          errors;

    function new();
      count = 0;
      gen = SEED_RESET;
      seed = SEED_RESET;
      diffuse = 1'b0;
      errors = 0;
      foreach (left_err[i]) left_err[i] = '0;
      foreach (col_set[i]) col_set[i] = 1'b0;
    endfunction

    function bit draw_bit();
      gen = gen * LCG_MULT + LCG_ADD;
      return gen[17];
    endfunction

    function void note_word(pixel_word_t w);
      map_code_t res;
      int px [3];
      int adj [3];
      int carry;
      int d;
      int t;
      int best;
      int best_d;
      bit pick;
      res.index = 8'd0;
      res.status = ST_OK;
      px[0] = int'(w.red);
      px[1] = int'(w.green);
      px[2] = int'(w.blue);
      case (w.action)
        ACT_APPEND: begin
          if (count >= PAL_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            res.index = count[7:0];
            pal[count] = {w.red, w.green, w.blue};
            count++;
          end
        end
        ACT_MAP: begin
          for (int ch = 0; ch < 3; ch++) begin
            pick = draw_bit();
            carry = 0;
            if (diffuse) begin
              if (pick) carry = w.row_start ? 0 : int'(left_err[ch]);
              else carry = w.first_row ? 0 : int'(col_err[w.column][ch]);
            end
            adj[ch] = px[ch] + carry;
            if (adj[ch] > 255) adj[ch] = 255;
            if (adj[ch] < 0) adj[ch] = 0;
          end
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            best = 0;
            best_d = 32'h7fff_ffff;
            for (int k = 0; k < count; k++) begin
              d = 0;
              for (int ch = 0; ch < 3; ch++) begin
                t = adj[ch] - int'(pal[k][23-8*ch -: 8]);
                d += t * t;
              end
              if (d < best_d) begin
                best_d = d;
                best = k;
              end
            end
            res.index = best[7:0];
            if (diffuse) begin
              for (int ch = 0; ch < 3; ch++) begin
                left_err[ch] = err_t'(px[ch] - int'(pal[best][23-8*ch -: 8]));
                col_err[w.column][ch] = left_err[ch];
              end
              col_set[w.column] = 1'b1;
            end
          end
        end
        ACT_START: begin
          gen = seed;
          foreach (left_err[i]) left_err[i] = '0;
        end
        default: ;
      endcase
      due.push_back(res);
    endfunction

    function void check_code(logic [7:0] index, status_t status);
      map_code_t exp_code;
      if (due.size() == 0) begin
        $display("%0t: unexpected word, index %0d status %0d", $time, index, status);
        errors++;
        return;
      end
      exp_code = due.pop_front();
      if (index !== exp_code.index) begin
        $display("%0t: color_index expected %0d actual %0d", $time, exp_code.index, index);
        errors++;
      end
      if (status !== exp_code.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_code.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [11:0] in_column = '0;
  logic        in_row_start = 1'b0;
  logic        in_first_row = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_color_index;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  palette_shadow sb = new();
  bit quiet = 1'b0;
  int cycles = 0;

  random_error_diffusion_palette_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_column(in_column), .in_row_start(in_row_start), .in_first_row(in_first_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_color_index(out_color_index), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("random_error_diffusion_palette_map_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_code(out_color_index, out_status);
    out_stall <= !quiet && ($urandom_range(99) < 24);
  end

  function automatic pixel_word_t make_word(action_t a, int r, int g, int b, int col,
                                            bit rs, bit fr);
    pixel_word_t w;
    w.action = a;
    w.red = r[7:0];
    w.green = g[7:0];
    w.blue = b[7:0];
    w.column = col[11:0];
    w.row_start = rs;
    w.first_row = fr;
    return w;
  endfunction

  function automatic int rand_chan();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(255);
  endfunction

  task automatic send_word(input pixel_word_t w);
    int gap;
    if (!quiet && $urandom_range(99) < 24) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // never read a column entry that no pixel has written
    if (w.action == ACT_MAP && sb.diffuse && !w.first_row && !sb.col_set[w.column])
      w.first_row = 1'b1;
    in_valid <= 1'b1;
    in_action <= w.action;
    in_red <= w.red;
    in_green <= w.green;
    in_blue <= w.blue;
    in_column <= w.column;
    in_row_start <= w.row_start;
    in_first_row <= w.first_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic drain_input();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_DIFFUSE) sb.diffuse = data[0];
    else sb.seed = data[47:0];
  endtask

  initial begin
    int cap;
    int width;
    int base;
    int x;
    int y;
    int roll;
    logic [47:0] seed_val;
    pixel_word_t w;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(ACT_MAP, 255, 0, 255, 0, 1, 1));
    send_word(make_word(ACT_UNUSED, 255, 255, 255, 4095, 1, 1));
    send_word(make_word(ACT_START, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 255, 255, 255, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 255, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 0, 255, 0, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 0, 0, 255, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 128, 128, 128, 0, 0, 0));
    send_word(make_word(ACT_APPEND, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_MAP, 0, 0, 0, 0, 1, 1));
    send_word(make_word(ACT_MAP, 255, 255, 255, 1, 0, 1));
    send_word(make_word(ACT_MAP, 64, 64, 64, 2, 0, 1));

    drain_input();
    write_reg(ADDR_DIFFUSE, 64'd1);
    write_reg(ADDR_SEED, 64'd0);
    send_word(make_word(ACT_START, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_MAP, 255, 255, 255, 0, 1, 1));
    send_word(make_word(ACT_MAP, 250, 3, 128, 1, 0, 1));
    send_word(make_word(ACT_MAP, 1, 254, 0, 2, 0, 1));
    send_word(make_word(ACT_MAP, 255, 255, 255, 0, 1, 0));
    send_word(make_word(ACT_MAP, 0, 0, 0, 1, 0, 0));
    send_word(make_word(ACT_MAP, 200, 10, 90, 2, 0, 0));

    drain_input();
    write_reg(ADDR_SEED, 64'h0000_FFFF_FFFF_FFFF);
    send_word(make_word(ACT_START, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_MAP, 17, 34, 51, 4095, 1, 1));
    send_word(make_word(ACT_MAP, 5, 250, 130, 0, 0, 0));

    for (int phase = 0; phase < 8; phase++) begin
      drain_input();
      if (phase == 0) seed_val = '0;
      else if (phase == 1) seed_val = '1;
      else seed_val = 48'({$urandom, $urandom});
      write_reg(ADDR_DIFFUSE, {63'd0, phase % 3 != 2});
      write_reg(ADDR_SEED, {16'd0, seed_val});
      quiet = (phase == 3);
      cap = (phase == 7) ? PAL_DEPTH : 8 + 6 * phase;
      width = $urandom_range(1, 24);
      base = $urandom_range(0, COL_DEPTH - width);
      x = 0;
      y = 0;
      send_word(make_word(ACT_START, 0, 0, 0, 0, 0, 0));
      if (phase == 7) begin
        while (sb.count < PAL_DEPTH) begin
          send_word(make_word(ACT_APPEND, rand_chan(), rand_chan(), rand_chan(), 0, 0, 0));
        end
        repeat (3) send_word(make_word(ACT_APPEND, rand_chan(), rand_chan(), rand_chan(),
                                       $urandom_range(4095), 1'($urandom_range(1)),
                                       1'($urandom_range(1))));
      end
      for (int n = 0; n < 150; n++) begin
        if (phase == 4 && n == 75) drain_input();
        roll = $urandom_range(99);
        if (roll < 6) begin
          w = make_word(action_t'($urandom_range(3)), rand_chan(), rand_chan(), rand_chan(),
                        $urandom_range(4095), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
          if (w.action == ACT_APPEND && sb.count >= cap) w.action = ACT_UNUSED;
          send_word(w);
        end else if (roll < 14 && sb.count < cap) begin
          send_word(make_word(ACT_APPEND, rand_chan(), rand_chan(), rand_chan(), 0, 0, 0));
        end else begin
          send_word(make_word(ACT_MAP, rand_chan(), rand_chan(), rand_chan(), base + x,
                              x == 0, y == 0));
          x++;
          if (x == width) begin
            x = 0;
            y++;
          end
        end
      end
    end

    drain_input();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("random_error_diffusion_palette_map_tb OK");
    end else begin
      $display("random_error_diffusion_palette_map_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
src/redpm_pkg.sv
src/redpm_ram.sv
src/random_error_diffusion_palette_map.sv
dv/random_error_diffusion_palette_map_tb.sv
